/* rtl/acl_pkg.sv */
package acl_pkg;

	localparam int LINE_MAX_DEF = 32;
	localparam int TICK_MS_DEF = 10;

	localparam logic [15:0] TIMEOUT_RST = 16'd3000;

	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_STD = 8'h74;
	localparam logic [7:0] CH_EXT = 8'h54;

	localparam logic [3:0] ID_STD_DIGITS = 4'd3;
	localparam logic [3:0] ID_EXT_DIGITS = 4'd8;
	localparam logic [4:0] DLC_MAX = 5'd8;
	localparam logic [5:0] RSP_LEN_MAX = 6'd63;

	typedef enum logic [1:0] {
		KIND_FRAME = 2'd0,
		KIND_RESPONSE = 2'd1,
		KIND_BELL = 2'd2
	} kind_t;

	typedef struct packed {
		logic [31:0] id;
		logic [3:0] dlc;
		logic [63:0] data;
	} frame_acc_t;

	// bit 4 set for a non-hex character
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 5'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 5'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 5'(c - 8'h37);
		end
		return v;
	endfunction

endpackage

/* rtl/acl_ifs.sv */
interface acl_char_if;
	logic valid;
	logic ready;
	logic operation;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface acl_result_if;
	import acl_pkg::*;
	logic valid;
	logic ready;
	kind_t kind;
	logic extended;
	logic [31:0] frame_id;
	logic [3:0] frame_length;
	logic [63:0] frame_data;
	logic [7:0] response_first;
	logic [5:0] response_length;

	modport source (output valid, output kind, output extended, output frame_id,
		output frame_length, output frame_data, output response_first,
		output response_length, input ready);
	modport sink (input valid, input kind, input extended, input frame_id,
		input frame_length, input frame_data, input response_first,
		input response_length, output ready);
endinterface

interface acl_cfg_if;
	logic valid;
	logic ready;
	logic [15:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/acl_frame_acc.sv */
module acl_frame_acc #(
	parameter int LINE_MAX = acl_pkg::LINE_MAX_DEF
) (
	input logic [$clog2(LINE_MAX+1)-1:0] pos,
	input logic ext,
	input logic [7:0] rx_byte,
	input acl_pkg::frame_acc_t acc_in,
	output acl_pkg::frame_acc_t acc_out,
	output logic bad
);
	import acl_pkg::*;

	localparam int CNT_W = $clog2(LINE_MAX + 1);
	localparam int CMP_W = CNT_W + 2;

	logic [4:0] hv;
	logic [CMP_W-1:0] nid;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] p;
	logic [3:0] nib;

	assign hv = hex_value(rx_byte);
	assign nid = CMP_W'(ext ? ID_EXT_DIGITS : ID_STD_DIGITS);
	assign pos_x = CMP_W'(pos);
	assign p = pos_x - nid - CMP_W'(2);
	// byte p/2, high nibble first
	assign nib = {p[3:1], ~p[0]};

	always_comb begin
		acc_out = acc_in;
		bad = 1'b0;
		if (pos_x <= nid) begin
			if (hv[4]) begin
				bad = 1'b1;
			end else begin
				acc_out.id = {acc_in.id[27:0], hv[3:0]};
			end
		end else if (pos_x == nid + CMP_W'(1)) begin
			if (hv > DLC_MAX) begin
				bad = 1'b1;
			end else begin
				acc_out.dlc = hv[3:0];
			end
		end else if (p < CMP_W'({acc_in.dlc, 1'b0})) begin
			if (hv[4]) begin
				bad = 1'b1;
			end else begin
				for (int i = 0; i < 16; i++) begin
					if (nib == 4'(i)) begin
						acc_out.data[4*i +: 4] = acc_in.data[4*i +: 4] | hv[3:0];
					end
				end
			end
		end
	end

endmodule

/* rtl/ascii_can_line_receiver.sv */
// path: an accepted item goes through the input register, then the result register
// throughput: one item per cycle unless a stalled result holds the input register
// an item leaves the input register as soon as no result waits unaccepted
// reset: asynchronous, clears the line, the idle timer and both registers' valid flags
// reset: line_timeout_ms returns to 3000
module ascii_can_line_receiver #(
	parameter int LINE_MAX = acl_pkg::LINE_MAX_DEF,
	parameter int TICK_MS = acl_pkg::TICK_MS_DEF
) (
	input logic clk,
	input logic arst_n,
	acl_char_if.sink chars,
	acl_result_if.source results,
	acl_cfg_if.sink cfg
);
	import acl_pkg::*;

	localparam int CNT_W = $clog2(LINE_MAX + 1);
	localparam int CMP_W = CNT_W + 2;
	localparam int TMR_W = $clog2(65536 + TICK_MS);

	logic valid_s1;
	logic op_s1;
	logic [7:0] byte_s1;
	logic adv;

	logic [15:0] timeout_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0] first_q;
	frame_acc_t acc_q;
	logic bad_q;
	logic [TMR_W-1:0] timer_q;

	logic [CNT_W-1:0] count_d;
	logic [7:0] first_d;
	frame_acc_t acc_d;
	logic bad_d;
	logic [TMR_W-1:0] timer_d;

	logic out_valid_q;
	kind_t kind_q;
	logic ext_q;
	logic [31:0] id_q;
	logic [3:0] len_q;
	logic [63:0] data_q;
	logic [7:0] rfirst_q;
	logic [5:0] rlen_q;

	logic emit;
	kind_t kind_d;
	logic ext_d;
	logic [31:0] id_d;
	logic [3:0] len_d;
	logic [63:0] data_d;
	logic [7:0] rfirst_d;
	logic [5:0] rlen_d;

	logic is_ext;
	logic is_frame;
	frame_acc_t acc_upd;
	logic frame_bad;
	logic [TMR_W-1:0] timer_inc;
	logic [CMP_W-1:0] count_x;
	logic [CMP_W-1:0] need;

	assign adv = valid_s1 && (!out_valid_q || results.ready);
	assign chars.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	assign is_ext = (first_q == CH_EXT);
	assign is_frame = is_ext || (first_q == CH_STD);
	assign timer_inc = timer_q + TMR_W'(TICK_MS);
	assign count_x = CMP_W'(count_q);
	assign need = CMP_W'(is_ext ? ID_EXT_DIGITS : ID_STD_DIGITS) + CMP_W'(2)
		+ CMP_W'({acc_q.dlc, 1'b0});

	acl_frame_acc #(
		.LINE_MAX(LINE_MAX)
	) u_frame_acc (
		.pos(count_q),
		.ext(is_ext),
		.rx_byte(byte_s1),
		.acc_in(acc_q),
		.acc_out(acc_upd),
		.bad(frame_bad)
	);

	always_comb begin
		count_d = count_q;
		first_d = first_q;
		acc_d = acc_q;
		bad_d = bad_q;
		timer_d = timer_q;
		emit = 1'b0;
		kind_d = KIND_BELL;
		ext_d = 1'b0;
		id_d = '0;
		len_d = '0;
		data_d = '0;
		rfirst_d = '0;
		rlen_d = '0;
		if (op_s1) begin
			if (count_q != '0) begin
				timer_d = timer_inc;
				if (timer_inc > TMR_W'(timeout_q)) begin
					count_d = '0;
					first_d = '0;
					acc_d = '0;
					bad_d = 1'b0;
				end
			end else begin
				timer_d = '0;
			end
		end else begin
			timer_d = '0;
			if (byte_s1 == CH_BEL) begin
				emit = 1'b1;
				kind_d = KIND_BELL;
				count_d = '0;
				first_d = '0;
				acc_d = '0;
				bad_d = 1'b0;
			end else if (byte_s1 == CH_CR) begin
				if (!bad_q && is_frame) begin
					if (count_x >= need) begin
						emit = 1'b1;
						kind_d = KIND_FRAME;
						ext_d = is_ext;
						id_d = acc_q.id;
						len_d = acc_q.dlc;
						data_d = acc_q.data;
					end
				end else if (!bad_q) begin
					emit = 1'b1;
					kind_d = KIND_RESPONSE;
					rfirst_d = first_q;
					rlen_d = (count_x > CMP_W'(RSP_LEN_MAX)) ? RSP_LEN_MAX : count_x[5:0];
				end
				count_d = '0;
				first_d = '0;
				acc_d = '0;
				bad_d = 1'b0;
			end else if (count_x >= CMP_W'(LINE_MAX)) begin
				bad_d = 1'b1;
			end else begin
				count_d = count_q + CNT_W'(1);
				if (count_q == '0) begin
					first_d = byte_s1;
				end else if (!bad_q && is_frame) begin
					acc_d = acc_upd;
					bad_d = frame_bad;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			op_s1 <= chars.operation;
			byte_s1 <= chars.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg.valid && cfg.ready) begin
			timeout_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			first_q <= '0;
			acc_q <= '0;
			bad_q <= 1'b0;
			timer_q <= '0;
		end else if (adv) begin
			count_q <= count_d;
			first_q <= first_d;
			acc_q <= acc_d;
			bad_q <= bad_d;
			timer_q <= timer_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			kind_q <= kind_d;
			ext_q <= ext_d;
			id_q <= id_d;
			len_q <= len_d;
			data_q <= data_d;
			rfirst_q <= rfirst_d;
			rlen_q <= rlen_d;
		end
	end

	assign results.valid = out_valid_q;
	assign results.kind = kind_q;
	assign results.extended = ext_q;
	assign results.frame_id = id_q;
	assign results.frame_length = len_q;
	assign results.frame_data = data_q;
	assign results.response_first = rfirst_q;
	assign results.response_length = rlen_q;

endmodule

/* rtl/acl_checker.sv */
module acl_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] out_kind,
	input logic out_extended,
	input logic [31:0] out_frame_id,
	input logic [3:0] out_frame_length,
	input logic [63:0] out_frame_data,
	input logic [7:0] out_response_first,
	input logic [5:0] out_response_length
);
	import acl_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_kind) && $stable(out_frame_id)
			&& $stable(out_frame_data) && $stable(out_response_length))
		else $error("result changed while stalled");

	// a fresh result follows an item accepted on the character channel
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without an item");

	a_bell_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_BELL |-> !out_extended && out_frame_id == '0
			&& out_frame_length == '0 && out_frame_data == '0
			&& out_response_first == '0 && out_response_length == '0)
		else $error("bell item carries data");

	a_frame_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_FRAME |-> out_frame_length <= 4'd8
			&& out_response_first == '0 && out_response_length == '0)
		else $error("bad frame item");

endmodule

bind ascii_can_line_receiver acl_checker u_acl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(chars.valid),
	.in_ready(chars.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_kind(results.kind),
	.out_extended(results.extended),
	.out_frame_id(results.frame_id),
	.out_frame_length(results.frame_length),
	.out_frame_data(results.frame_data),
	.out_response_first(results.response_first),
	.out_response_length(results.response_length)
);
